// ----- rtl/core/cce_pkg.sv -----
package cce_pkg;

    // encoding geometry
    localparam int unsigned CELL_W     = 32;
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned MAX_GROUPS = 5;
    localparam int unsigned DATA_W     = GROUP_BITS * MAX_GROUPS;
    localparam int unsigned CNT_W      = 3;

    // compact mode after reset
    localparam logic COMPACT_RESET = 1'b1;

    // shift unit operations
    typedef logic [1:0] shift_op_t;
    localparam shift_op_t SH_NONE   = 2'd0;
    localparam shift_op_t SH_ARITH7 = 2'd1;
    localparam shift_op_t SH_LOGIC7 = 2'd2;
    localparam shift_op_t SH_BYTE   = 2'd3;

endpackage

// ----- rtl/core/cce_shift_unit.sv -----
module cce_shift_unit
(
    input  cce_pkg::shift_op_t               op,
    input  logic [cce_pkg::DATA_W-1:0]       data,
    output logic [cce_pkg::DATA_W-1:0]       shifted
);

    // right shift by one group (arithmetic or logical) or one byte, else pass through
    always_comb
    begin
        case (op)
            cce_pkg::SH_ARITH7:
                shifted = {{cce_pkg::GROUP_BITS{data[cce_pkg::DATA_W-1]}},
                           data[cce_pkg::DATA_W-1:cce_pkg::GROUP_BITS]};
            cce_pkg::SH_LOGIC7:
                shifted = {{cce_pkg::GROUP_BITS{1'b0}},
                           data[cce_pkg::DATA_W-1:cce_pkg::GROUP_BITS]};
            cce_pkg::SH_BYTE:
                shifted = {{cce_pkg::BYTE_BITS{1'b0}},
                           data[cce_pkg::DATA_W-1:cce_pkg::BYTE_BITS]};
            default:
                shifted = data;
        endcase
    end

endmodule

// ----- rtl/core/compact_cell_encoder_core.sv -----
// sequence: compact mode, n groups (1..5): the groups are scanned, then emitted one word
//   per cycle, most significant group first; plain mode: 4 words, low byte first. words are
//   registered. busy stays high through the scan and emit states. the single shared shifter
//   is used once per cycle. the receiver cannot stall.
// reset (rst_n low, asynchronous): idle, no word pending, compact mode on.
module compact_cell_encoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] cell_value,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output logic        result_valid,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int unsigned DW = cce_pkg::DATA_W;
    localparam int unsigned CW = cce_pkg::CELL_W;
    localparam int unsigned GB = cce_pkg::GROUP_BITS;

    logic [1:0]                  state_reg,  state_next;
    logic                        compact_reg;
    logic                        mode_reg,   mode_next;
    logic [cce_pkg::CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [CW-1:0]               val_reg,    val_next;
    logic [DW-1:0]               stack_reg,  stack_next;
    logic                        valid_reg,  valid_next;
    logic [7:0]                  byte_reg,   byte_next;
    logic                        last_reg,   last_next;

    cce_pkg::shift_op_t          sh_op;
    logic [DW-1:0]               sh_in;
    logic [DW-1:0]               sh_out;
    logic [GB-1:0]               grp;
    logic                        stop;
    logic                        accept;

    // shared shifter
    cce_shift_unit u_shift
    (
        .op      (sh_op),
        .data    (sh_in),
        .shifted (sh_out)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign grp    = val_reg[GB-1:0];

    // shifter operand select
    always_comb
    begin
        sh_op = cce_pkg::SH_NONE;
        sh_in = stack_reg;
        case (state_reg)
            ST_SCAN:
            begin
                sh_op = cce_pkg::SH_ARITH7;
                sh_in = {{(DW - CW){val_reg[CW-1]}}, val_reg};
            end
            ST_EMIT:
            begin
                if (mode_reg)
                begin
                    sh_op = cce_pkg::SH_LOGIC7;
                    sh_in = stack_reg;
                end
                else
                begin
                    sh_op = cce_pkg::SH_BYTE;
                    sh_in = {{(DW - CW){1'b0}}, val_reg};
                end
            end
            default:
            begin
                sh_op = cce_pkg::SH_NONE;
                sh_in = stack_reg;
            end
        endcase
    end

    // remainder is pure sign extension, or group limit reached
    assign stop = ((sh_out[CW-1:0] == {CW{1'b0}}) && !grp[GB-1]) ||
                  ((sh_out[CW-1:0] == {CW{1'b1}}) && grp[GB-1]) ||
                  (cnt_reg == cce_pkg::CNT_W'(cce_pkg::MAX_GROUPS - 1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        stack_next = stack_reg;
        valid_next = 1'b0;
        byte_next  = byte_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next   = cell_value;
                    mode_next  = compact_reg;
                    stack_next = '0;
                    if (compact_reg)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cnt_next   = cce_pkg::CNT_W'(cce_pkg::WORD_BYTES);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                // push group; last pushed pops first
                stack_next = {stack_reg[DW-GB-1:0], grp};
                val_next   = sh_out[CW-1:0];
                cnt_next   = cnt_reg + 1'b1;
                if (stop)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                last_next  = (cnt_reg == cce_pkg::CNT_W'(1));
                if (mode_reg)
                begin
                    byte_next  = {(cnt_reg != cce_pkg::CNT_W'(1)), stack_reg[GB-1:0]};
                    stack_next = sh_out;
                end
                else
                begin
                    byte_next = val_reg[7:0];
                    val_next  = sh_out[CW-1:0];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == cce_pkg::CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            compact_reg <= cce_pkg::COMPACT_RESET;
            valid_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                compact_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        val_reg   <= val_next;
        stack_reg <= stack_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign last_byte    = last_reg;

endmodule
